// ===== design/mnps_pkg.sv =====
// Shared types and constants for the mono note priority stack.
// Holds the event codes, field widths and the control bundle sent to the stack cells.
// Has no dependencies. The cell and the top level refer to it by scoped names.
package mnps_pkg;

  // Payload field widths.
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int COUNT_W = 5;
  localparam int OP_W    = 2;

  // Default number of held notes.
  localparam int DEFAULT_STACK_DEPTH = 16;

  // Event codes carried in the operation field.
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_VOICE_MODE = 1'b0;

  // Voice modes.
  localparam logic MODE_MONO = 1'b0;

  // Commands broadcast to every cell of the stack.
  typedef struct packed {
    logic              push;
    logic              capture;
    logic              scan;
    logic              remove;
    logic [NOTE_W-1:0] note;
  } cell_ctrl_t;

endpackage

// ===== design/mnps_cell.sv =====
// One entry of the held-note stack, built as a cell of a shift chain.
// Depends on mnps_pkg for the note width and the cell control bundle.
module mnps_cell (
  input  logic                            clk,
  input  mnps_pkg::cell_ctrl_t            ctrl,
  input  logic                            in_range,
  input  logic [mnps_pkg::NOTE_W-1:0]     lower_entry,
  input  logic                            lower_below,
  input  logic [mnps_pkg::NOTE_W-1:0]     upper_entry,
  output logic [mnps_pkg::NOTE_W-1:0]     entry,
  output logic                            below_out
);

  logic [mnps_pkg::NOTE_W-1:0] entry_r;
  logic                        hit_r;
  logic                        below_r;

  // A push moves every entry one place toward the old end. A removal pulls
  // entries down from the neighbor above, starting at the newest match.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry_r <= lower_entry;
    end else if (ctrl.remove && (hit_r || below_r)) begin
      entry_r <= upper_entry;
    end
  end

  // The "match somewhere newer" flag ripples one cell per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit_r   <= in_range && (entry_r == ctrl.note);
      below_r <= 1'b0;
    end else if (ctrl.scan) begin
      below_r <= lower_below;
    end
  end

  assign entry     = entry_r;
  assign below_out = below_r || hit_r;

endmodule

// ===== design/mono_note_priority_stack.sv =====
// Top level of the monophonic last-note-priority voice controller.
// Depends on mnps_pkg and instantiates a chain of mnps_cell stack entries.
//
// This block follows note-on, note-off and all-notes-off transactions and
// returns exactly one result transaction for each input transaction: gate,
// retrigger flag, sounding note, sounding velocity and the number of held
// notes. Held notes sit in a chain of STACK_DEPTH cells with the newest note
// in cell 0, so a note-on shifts the whole chain by one place and the oldest
// note falls off the far end when the stack is full. A note-on, an
// all-notes-off or the unused event code goes from acceptance straight to
// the FINISH state, which loads the result register and returns the block
// to idle. For a note-off every cell compares its note with the event at
// the accepting edge, then in the SCAN state a "newer match" flag ripples
// down the chain one cell per cycle so that only the newest matching entry
// is removed, the REMOVE state shifts the entries above it down, and the
// FINISH state loads the result. One transaction is in progress at a time;
// in_ready is high while the block is idle, and a finished result waits in
// the output register, so a new transaction may be accepted while the
// previous result has not yet been taken. That next transaction then holds
// in its last step, with in_ready low, for as long as the output register
// stays full. The voice_mode register (byte address 0) selects mono mode
// with retrigger (0) or legato mode (1); it must be written through the
// APB-style port only while no transaction is in progress, which the block
// itself does not enforce, and it reads back its value.
module mono_note_priority_stack #(
  parameter int STACK_DEPTH = mnps_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input event channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mnps_pkg::OP_W-1:0]         in_operation,
  input  logic [mnps_pkg::NOTE_W-1:0]       in_note,
  input  logic [mnps_pkg::VEL_W-1:0]        in_velocity,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_gate,
  output logic                              out_retrigger,
  output logic [mnps_pkg::NOTE_W-1:0]       out_sounding_note,
  output logic [mnps_pkg::VEL_W-1:0]        out_sounding_velocity,
  output logic [mnps_pkg::COUNT_W-1:0]      out_held_count,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mnps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mnps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mnps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SCAN_W = $clog2(STACK_DEPTH);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(STACK_DEPTH - 2);
  localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(STACK_DEPTH);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_REMOVE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [SCAN_W-1:0]              scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           gate_r, gate_nxt;
  logic [mnps_pkg::NOTE_W-1:0]    cur_note_r, cur_note_nxt;
  logic [mnps_pkg::VEL_W-1:0]     cur_vel_r, cur_vel_nxt;
  logic                           retrig_r, retrig_nxt;
  logic [mnps_pkg::OP_W-1:0]      op_r, op_nxt;
  logic                           voice_mode_r;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_gate_r;
  logic                           out_retrig_r;
  logic [mnps_pkg::NOTE_W-1:0]    out_note_r;
  logic [mnps_pkg::VEL_W-1:0]     out_vel_r;
  logic [mnps_pkg::COUNT_W-1:0]   out_count_r;

  logic                           accept;
  logic                           out_free;
  logic                           load_out;
  logic                           any_match;
  mnps_pkg::cell_ctrl_t           cell_ctrl;

  logic [mnps_pkg::NOTE_W-1:0]    entry_w [STACK_DEPTH];
  logic                           below_w [STACK_DEPTH];
  logic                           in_range_w [STACK_DEPTH];

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign load_out = (state_r == ST_FINISH) && out_free;

  // The top cell's flag covers every entry once the ripple has finished.
  assign any_match = below_w[STACK_DEPTH-1];

  // Commands to the cell chain.
  always_comb begin
    cell_ctrl.push    = accept && (in_operation == mnps_pkg::OP_NOTE_ON);
    cell_ctrl.capture = accept && (in_operation == mnps_pkg::OP_NOTE_OFF);
    cell_ctrl.scan    = (state_r == ST_SCAN);
    cell_ctrl.remove  = (state_r == ST_REMOVE);
    cell_ctrl.note    = in_note;
  end

  // The chain: cell 0 holds the newest note. Each cell takes its pushed value
  // from the cell below and its pulled value from the cell above.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [mnps_pkg::NOTE_W-1:0] lower_entry;
    logic                        lower_below;
    logic [mnps_pkg::NOTE_W-1:0] upper_entry;

    assign in_range_w[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lower_entry = in_note;
      assign lower_below = 1'b0;
    end else begin : g_mid
      assign lower_entry = entry_w[i-1];
      assign lower_below = below_w[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign upper_entry = entry_w[i];
    end else begin : g_inner
      assign upper_entry = entry_w[i+1];
    end

    mnps_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .in_range    (in_range_w[i]),
      .lower_entry (lower_entry),
      .lower_below (lower_below),
      .upper_entry (upper_entry),
      .entry       (entry_w[i]),
      .below_out   (below_w[i])
    );
  end

  // Sequencer and voice state.
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    count_nxt    = count_r;
    gate_nxt     = gate_r;
    cur_note_nxt = cur_note_r;
    cur_vel_nxt  = cur_vel_r;
    retrig_nxt   = retrig_r;
    op_nxt       = op_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_operation;
          retrig_nxt = 1'b0;
          state_nxt  = ST_FINISH;
          case (in_operation)
            mnps_pkg::OP_NOTE_ON: begin
              // A full stack loses its oldest note, so the count stays put.
              if (count_r != COUNT_FULL) begin
                count_nxt = count_r + 1'b1;
              end
              cur_note_nxt = in_note;
              cur_vel_nxt  = in_velocity;
              gate_nxt     = 1'b1;
              retrig_nxt   = (count_r != '0) && (voice_mode_r == mnps_pkg::MODE_MONO);
            end
            mnps_pkg::OP_NOTE_OFF: begin
              scan_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            mnps_pkg::OP_ALL_OFF: begin
              count_nxt = '0;
              gate_nxt  = 1'b0;
            end
            default: begin
              // Unused code: report the present state unchanged.
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == SCAN_LAST) begin
          state_nxt = ST_REMOVE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      ST_REMOVE: begin
        if (any_match) begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          // After a note-off the voice falls back to the newest held note.
          if (op_r == mnps_pkg::OP_NOTE_OFF) begin
            if (count_r == '0) begin
              gate_nxt = 1'b0;
            end else begin
              cur_note_nxt = entry_w[0];
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
      count_r    <= '0;
      gate_r     <= 1'b0;
      cur_note_r <= '0;
      cur_vel_r  <= '0;
      retrig_r   <= 1'b0;
      op_r       <= mnps_pkg::OP_NOTE_ON;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      count_r    <= count_nxt;
      gate_r     <= gate_nxt;
      cur_note_r <= cur_note_nxt;
      cur_vel_r  <= cur_vel_nxt;
      retrig_r   <= retrig_nxt;
      op_r       <= op_nxt;
    end
  end

  // Output register. The held count is reported in five bits.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_gate_r   <= gate_nxt;
      out_retrig_r <= retrig_r;
      out_note_r   <= cur_note_nxt;
      out_vel_r    <= cur_vel_r;
      out_count_r  <= mnps_pkg::COUNT_W'(count_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_gate              = out_gate_r;
  assign out_retrigger         = out_retrig_r;
  assign out_sounding_note     = out_note_r;
  assign out_sounding_velocity = out_vel_r;
  assign out_held_count        = out_count_r;

  // Configuration register. Only the word at address 0 exists.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_mode_r <= mnps_pkg::MODE_MONO;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == mnps_pkg::REG_IDX_VOICE_MODE)) begin
      voice_mode_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mnps_pkg::REG_IDX_VOICE_MODE) begin
      prdata[0] = voice_mode_r;
    end
  end

  assign pready = 1'b1;

endmodule

// ===== design/mnps_checker.sv =====
// Port-level checks for the mono note priority stack.
// Depends only on the top level's ports; bound to mono_note_priority_stack below.
module mnps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_gate,
  input logic       out_retrigger,
  input logic [6:0] out_sounding_note,
  input logic [6:0] out_sounding_velocity,
  input logic [4:0] out_held_count
);

  // A waiting result holds its place and its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gate)
      && $stable(out_retrigger) && $stable(out_sounding_note)
      && $stable(out_sounding_velocity) && $stable(out_held_count))
    else $error("result changed while stalled");

  // Held notes mean the gate is open.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_held_count != 5'd0) |-> out_gate)
    else $error("notes held but gate closed");

  // A retrigger only comes with an open gate.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_retrigger |-> out_gate && (out_held_count != 5'd0))
    else $error("retrigger without a sounding note");

  // One transaction at a time: no acceptance in the cycle after one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two transactions back to back");

  // Reset leaves the block idle with no result pending.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind mono_note_priority_stack mnps_checker u_mnps_checker (.*);

// ===== sim/mnps_voice_checker.sv =====
// Checker for the mono note priority stack: watches the event, result and register ports.
// Keeps its own model of the held-note stack and compares every result with it.
// Depends on mnps_pkg for field widths, event codes and the register address.
module mnps_voice_checker
  import mnps_pkg::*;
#(
  parameter int DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [NOTE_W-1:0]     in_note,
  input  logic [VEL_W-1:0]      in_velocity,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_gate,
  input  logic                  out_retrigger,
  input  logic [NOTE_W-1:0]     out_sounding_note,
  input  logic [VEL_W-1:0]      out_sounding_velocity,
  input  logic [COUNT_W-1:0]    out_held_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int unsigned           fault_total,
  output int unsigned           open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] VOICE_MODE_ADDR = CFG_ADDR_W'(4 * REG_IDX_VOICE_MODE);
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic               gate;
    logic               retrigger;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   velocity;
    logic [COUNT_W-1:0] held;
  } voice_result_t;

  // Model state. Entry 0 of held_notes is the oldest note.
  logic [NOTE_W-1:0] held_notes [DEPTH];
  int                n_held;
  logic              gate_q;
  logic [NOTE_W-1:0] cur_note;
  logic [VEL_W-1:0]  cur_vel;
  logic              mode_q;

  voice_result_t voice_results_due [$];
  int unsigned   faults;

  assign fault_total = faults;

  task automatic log_mismatch(input string msg);
    if (faults < MAX_PRINTED)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    faults++;
  endtask

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < n_held; i++)
      held_notes[i] = held_notes[i + 1];
    n_held--;
  endfunction

  // Applies one event to the model and returns what the voice reports after it.
  function automatic voice_result_t play_event(input logic [OP_W-1:0] op,
                                               input logic [NOTE_W-1:0] note,
                                               input logic [VEL_W-1:0] vel);
    voice_result_t r;
    logic          was_empty;
    bit            found;
    r.retrigger = 1'b0;
    case (op)
      OP_NOTE_ON: begin
        was_empty = (n_held == 0);
        if (n_held >= DEPTH)
          drop_entry(0);
        held_notes[n_held] = note;
        n_held++;
        cur_note = note;
        cur_vel = vel;
        r.retrigger = !was_empty && (mode_q == MODE_MONO);
        gate_q = 1'b1;
      end
      OP_NOTE_OFF: begin
        found = 1'b0;
        for (int pos = n_held - 1; pos >= 0 && !found; pos--) begin
          if (held_notes[pos] == note) begin
            drop_entry(pos);
            found = 1'b1;
          end
        end
        if (n_held == 0)
          gate_q = 1'b0;
        else
          cur_note = held_notes[n_held - 1];
      end
      OP_ALL_OFF: begin
        n_held = 0;
        gate_q = 1'b0;
      end
      default: ;
    endcase
    r.gate = gate_q;
    r.note = cur_note;
    r.velocity = cur_vel;
    r.held = COUNT_W'(n_held);
    return r;
  endfunction

  always @(posedge clk) begin
    voice_result_t want;
    voice_result_t got;
    if (!rst_n) begin
      n_held = 0;
      gate_q = 1'b0;
      cur_note = '0;
      cur_vel = '0;
      mode_q = MODE_MONO;
      voice_results_due.delete();
      faults = 0;
      open_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == VOICE_MODE_ADDR)
        mode_q = pwdata[0];
      if (in_valid && in_ready)
        voice_results_due = {voice_results_due,
                             play_event(in_operation, in_note, in_velocity)};
      if (out_valid && out_ready) begin
        got = '{out_gate, out_retrigger, out_sounding_note, out_sounding_velocity,
                out_held_count};
        if (voice_results_due.size() == 0) begin
          log_mismatch("result transaction with nothing outstanding");
        end else begin
          want = voice_results_due.pop_front();
          if (got.gate !== want.gate)
            log_mismatch($sformatf("gate got %0b want %0b", got.gate, want.gate));
          if (got.retrigger !== want.retrigger)
            log_mismatch($sformatf("retrigger got %0b want %0b",
                                   got.retrigger, want.retrigger));
          if (got.note !== want.note)
            log_mismatch($sformatf("sounding_note got %0d want %0d", got.note, want.note));
          if (got.velocity !== want.velocity)
            log_mismatch($sformatf("sounding_velocity got %0d want %0d",
                                   got.velocity, want.velocity));
          if (got.held !== want.held)
            log_mismatch($sformatf("held_count got %0d want %0d", got.held, want.held));
        end
      end
      open_count <= voice_results_due.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Top of the testbench for mono_note_priority_stack: clock, reset, stimulus and verdict.
// Depends on mnps_pkg, the design files and mnps_voice_checker, which does all checking that feeds the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mnps_pkg::*;

  localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;

  // The event code the block does not use; it must leave the voice untouched.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic MODE_LEGATO = ~MODE_MONO;
  localparam logic [CFG_ADDR_W-1:0] VOICE_MODE_ADDR = CFG_ADDR_W'(4 * REG_IDX_VOICE_MODE);

  // Items per random phase; four phases alternate between the two voice modes.
  localparam int PHASE_ITEMS = 150;
  // Length of the single deliberate receiver hold-off that backs the block up.
  localparam int SQUEEZE_CYCLES = 250;
  // Settling time after the last result, longer than a whole note-off.
  localparam int DRAIN_CYCLES = STACK_DEPTH + 10;
  // Generous watchdog, many times the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_operation = OP_NOTE_ON;
  logic [NOTE_W-1:0]     in_note = '0;
  logic [VEL_W-1:0]      in_velocity = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_gate;
  logic                  out_retrigger;
  logic [NOTE_W-1:0]     out_sounding_note;
  logic [VEL_W-1:0]      out_sounding_velocity;
  logic [COUNT_W-1:0]    out_held_count;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;

  // Handshake between the stimulus and the receiver for the long hold-off.
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;
  // Remaining transactions the sender offers back to back without gaps.
  int tx_calm_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mono_note_priority_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_note(in_note),
    .in_velocity(in_velocity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_gate(out_gate),
    .out_retrigger(out_retrigger),
    .out_sounding_note(out_sounding_note),
    .out_sounding_velocity(out_sounding_velocity),
    .out_held_count(out_held_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // The checker sits beside the block and sees the same pins, all but prdata.
  mnps_voice_checker #(
    .DEPTH(STACK_DEPTH)
  ) voice_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_note(in_note),
    .in_velocity(in_velocity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_gate(out_gate),
    .out_retrigger(out_retrigger),
    .out_sounding_note(out_sounding_note),
    .out_sounding_velocity(out_sounding_velocity),
    .out_held_count(out_held_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .fault_total(fail_count),
    .open_count(pending)
  );

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Offers one event transaction and returns at the edge where it is accepted.
  // Before the offer the sender may idle for a random gap: mostly none or a few
  // cycles, now and then a long one, and occasionally a run of back-to-back
  // transactions so the block also sees a saturated input.
  task automatic offer_midi_event(input logic [OP_W-1:0] op,
                                  input logic [NOTE_W-1:0] note,
                                  input logic [VEL_W-1:0] vel);
    int gap;
    int r;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        tx_calm_left = $urandom_range(20, 60);
        gap = 0;
      end else if (r < 60) begin
        gap = 0;
      end else if (r < 88) begin
        gap = $urandom_range(1, 3);
      end else if (r < 97) begin
        gap = $urandom_range(4, 12);
      end else begin
        gap = $urandom_range(20, 50);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_note <= note;
    in_velocity <= vel;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every outstanding result has been taken.
  // The checker's count is registered, hence the first wait.
  task automatic drain_voice();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle until pready.
  task automatic set_voice_mode(input logic mode);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VOICE_MODE_ADDR;
    pwdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random traffic shaped like playing: each phrase draws a small pool of notes
  // so that note-offs usually find a held match, duplicates pile up and the
  // newest-match rule matters. Some phrases are pure note-on pile-ups that
  // overflow the stack. A minority of events are stray note-offs, all-notes-off
  // and the unused event code.
  task automatic play_phrases(input int count);
    logic [NOTE_W-1:0] pool [6];
    int sent;
    int psize;
    int plen;
    int r;
    bit pile;
    sent = 0;
    while (sent < count) begin
      psize = $urandom_range(1, 6);
      for (int k = 0; k < psize; k++)
        pool[k] = NOTE_W'($urandom_range(0, 127));
      pile = ($urandom_range(0, 5) == 0);
      plen = pile ? $urandom_range(18, 26) : $urandom_range(4, 40);
      for (int k = 0; k < plen && sent < count; k++) begin
        r = $urandom_range(0, 99);
        if (pile || r < 55) begin
          offer_midi_event(OP_NOTE_ON, pool[$urandom_range(0, psize - 1)],
                           VEL_W'($urandom_range(0, 127)));
        end else if (r < 88) begin
          offer_midi_event(OP_NOTE_OFF, pool[$urandom_range(0, psize - 1)],
                           VEL_W'($urandom_range(0, 127)));
        end else if (r < 93) begin
          offer_midi_event(OP_NOTE_OFF, NOTE_W'($urandom_range(0, 127)),
                           VEL_W'($urandom_range(0, 127)));
        end else if (r < 97) begin
          offer_midi_event(OP_ALL_OFF, NOTE_W'($urandom_range(0, 127)),
                           VEL_W'($urandom_range(0, 127)));
        end else begin
          offer_midi_event(OP_UNUSED, NOTE_W'($urandom_range(0, 127)),
                           VEL_W'($urandom_range(0, 127)));
        end
        // Ignored events do not count toward the phase size.
        if (!(r >= 97 && !pile))
          sent++;
      end
    end
  endtask

  // Receiver. Alternates a stall of random length with a run of ready cycles.
  // Stalls are mostly absent or short, occasionally long, and now and then a
  // long stall-free stretch follows. Once, on request, it holds off for
  // SQUEEZE_CYCLES while the sender keeps offering, so the block backs up.
  initial begin
    int lo;
    int hi;
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (squeeze_req && !squeeze_done) begin
        lo = SQUEEZE_CYCLES;
        hi = $urandom_range(1, 8);
        squeeze_done = 1'b1;
      end else if (r < 10) begin
        lo = 0;
        hi = $urandom_range(40, 120);
      end else begin
        hi = $urandom_range(1, 8);
        if (r < 55)
          lo = 0;
        else if (r < 80)
          lo = $urandom_range(1, 3);
        else if (r < 95)
          lo = $urandom_range(4, 12);
        else
          lo = $urandom_range(20, 60);
      end
      if (lo > 0) begin
        out_ready <= 1'b0;
        repeat (lo) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (hi) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part in mono mode. The register is written explicitly even
    // though mono is its reset value.
    set_voice_mode(MODE_MONO);
    // First note on an empty stack: no retrigger. Field minimums.
    offer_midi_event(OP_NOTE_ON, 7'd0, 7'd0);
    // Second held note in mono mode retriggers. Field maximums.
    offer_midi_event(OP_NOTE_ON, 7'd127, 7'd127);
    // Releasing the newest note falls back to the older one.
    offer_midi_event(OP_NOTE_OFF, 7'd127, 7'd0);
    // A note-off that matches nothing re-sounds the newest held note.
    offer_midi_event(OP_NOTE_OFF, 7'd99, 7'd127);
    // The unused event code changes nothing.
    offer_midi_event(OP_UNUSED, 7'd127, 7'd127);
    // Last note released: gate drops, velocity of the last note-on stays.
    offer_midi_event(OP_NOTE_OFF, 7'd0, 7'd64);
    // Unmatched note-off on an empty stack.
    offer_midi_event(OP_NOTE_OFF, 7'd5, 7'd5);
    // Seventeen note-ons with repeated pitches: the last one overflows the
    // stack and drops the oldest entry.
    for (int i = 0; i <= STACK_DEPTH; i++)
      offer_midi_event(OP_NOTE_ON, NOTE_W'(20 + i % 8), VEL_W'(i * 7));
    // Releases only the newest of the duplicate entries.
    offer_midi_event(OP_NOTE_OFF, 7'd20, 7'd0);
    offer_midi_event(OP_ALL_OFF, 7'd0, 7'd0);
    drain_voice();

    // Directed part in legato mode: a new note over held notes never retriggers.
    set_voice_mode(MODE_LEGATO);
    offer_midi_event(OP_NOTE_ON, 7'd64, 7'd100);
    offer_midi_event(OP_NOTE_ON, 7'd65, 7'd1);
    offer_midi_event(OP_NOTE_ON, 7'd64, 7'd64);
    offer_midi_event(OP_NOTE_OFF, 7'd64, 7'd0);
    offer_midi_event(OP_ALL_OFF, 7'd64, 7'd0);
    drain_voice();

    // Random phases, alternating modes; the register is only rewritten once
    // the block has delivered every result. The long receiver hold-off is
    // requested at the start of the first phase.
    for (int ph = 0; ph < 4; ph++) begin
      set_voice_mode(ph % 2 == 0 ? MODE_MONO : MODE_LEGATO);
      if (ph == 0)
        squeeze_req = 1'b1;
      play_phrases(PHASE_ITEMS);
      drain_voice();
    end

    // Give any stray result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ===== mono_note_priority_stack.f =====
design/mnps_pkg.sv
design/mnps_cell.sv
design/mono_note_priority_stack.sv
design/mnps_checker.sv
sim/mnps_voice_checker.sv
sim/tb.sv
